// File: sv/toso_pkg.sv
// ----------------------------------------------------------------------------
// toso_pkg
// Shared widths, register indexes and handshake structs for the third-order
// state observer.
// ----------------------------------------------------------------------------
package toso_pkg;

    // word field widths
    localparam int ANGLE_W    = 32;
    localparam int EFFORT_W   = 32;
    localparam int STEP_W     = 24;
    localparam int OUT_W      = 32;
    localparam int BW_W       = 16;
    localparam int B0_W       = 32;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BANDWIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL_GAIN = 2'd1;

    // gain widths: 3*wo, 3*wo^2, wo^3 and the intermediate wo^2
    localparam int G1_W = 18;
    localparam int G2_W = 34;
    localparam int G3_W = 48;
    localparam int SQ_W = 32;

    // fixed-point alignment shifts
    localparam int ANGLE_SHIFT = 8;
    localparam int GAIN1_FRAC  = 6;
    localparam int GAIN2_FRAC  = 12;
    localparam int GAIN3_FRAC  = 18;
    localparam int STEP_FRAC   = 24;
    localparam int B0U_SHIFT   = 8;
    localparam int OUT_SHIFT   = 8;
    localparam int BU_W        = B0_W + EFFORT_W - B0U_SHIFT;

    // shared multiplier: b operand is cut into 16-bit digits
    localparam int OPB_W     = 64;
    localparam int DIGIT_W   = 16;
    localparam int DIG_IDX_W = 2;

    // index of the most significant digit used for each b operand
    localparam logic [DIG_IDX_W-1:0] MSD_BW     = 2'd1;
    localparam logic [DIG_IDX_W-1:0] MSD_SQ     = 2'd2;
    localparam logic [DIG_IDX_W-1:0] MSD_G1     = 2'd1;
    localparam logic [DIG_IDX_W-1:0] MSD_G2     = 2'd2;
    localparam logic [DIG_IDX_W-1:0] MSD_G3     = 2'd3;
    localparam logic [DIG_IDX_W-1:0] MSD_STEP   = 2'd1;
    localparam logic [DIG_IDX_W-1:0] MSD_EFFORT = 2'd1;

    typedef struct packed {
        logic                 start;
        logic [DIG_IDX_W-1:0] msd;
    } mul_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

endpackage

// File: sv/toso_if.sv
// ----------------------------------------------------------------------------
// toso_if
// Valid/ready channels of the state observer: sample in, estimates out and
// register writes.
// ----------------------------------------------------------------------------
interface toso_sample_if;
    import toso_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [ANGLE_W-1:0]  measured_angle;
    logic signed [EFFORT_W-1:0] control_effort;
    logic        [STEP_W-1:0]   step_time;

    modport source (output valid, measured_angle, control_effort, step_time, input ready);
    modport sink   (input valid, measured_angle, control_effort, step_time, output ready);
endinterface

interface toso_est_if;
    import toso_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] angle_estimate;
    logic signed [OUT_W-1:0] rate_estimate;
    logic signed [OUT_W-1:0] disturbance_estimate;

    modport source (output valid, angle_estimate, rate_estimate, disturbance_estimate,
                    input ready);
    modport sink   (input valid, angle_estimate, rate_estimate, disturbance_estimate,
                    output ready);
endinterface

interface toso_cfg_if;
    import toso_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/toso_mul.sv
// ----------------------------------------------------------------------------
// toso_mul
// Shared digit-serial multiplier: signed a times signed b, one 16-bit digit
// of b per cycle, most significant digit first, registered product then
// Horner accumulation.
// ----------------------------------------------------------------------------
module toso_mul #(
    parameter int AW = 48
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  toso_pkg::mul_req_t                      req,
    input  logic signed [AW-1:0]                    a,
    input  logic signed [toso_pkg::OPB_W-1:0]       b,
    output toso_pkg::mul_stat_t                     stat,
    output logic signed [AW+toso_pkg::OPB_W-1:0]    p
);
    import toso_pkg::*;

    localparam int PW    = AW + DIGIT_W + 1;
    localparam int ACC_W = AW + OPB_W;

    logic signed [AW-1:0]    a_reg;
    logic        [OPB_W-1:0] b_reg;
    logic [DIG_IDX_W-1:0]    dig_reg;
    logic [DIG_IDX_W-1:0]    msd_reg;
    logic                    run_reg;
    logic                    first_reg;
    logic signed [PW-1:0]    prod_reg;
    logic                    pv_reg;
    logic                    pfirst_reg;
    logic                    plast_reg;
    logic signed [ACC_W-1:0] acc_reg;
    logic                    done_reg;

    logic        [DIGIT_W-1:0] chunk;
    logic signed [DIGIT_W:0]   digit;
    logic signed [PW-1:0]      prod_next;
    logic signed [ACC_W-1:0]   acc_next;

    always_comb
    begin
        chunk = b_reg[dig_reg*DIGIT_W +: DIGIT_W];
        // only the top digit carries the sign
        if (dig_reg == msd_reg)
        begin
            digit = $signed({chunk[DIGIT_W-1], chunk});
        end
        else
        begin
            digit = $signed({1'b0, chunk});
        end
        prod_next = a_reg * digit;
        if (pfirst_reg)
        begin
            acc_next = ACC_W'(prod_reg);
        end
        else
        begin
            acc_next = (acc_reg <<< DIGIT_W) + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            pv_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            if (req.start)
            begin
                run_reg <= 1'b1;
            end
            else if (run_reg && dig_reg == '0)
            begin
                run_reg <= 1'b0;
            end
            pv_reg   <= run_reg;
            done_reg <= pv_reg && plast_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg     <= a;
            b_reg     <= b;
            dig_reg   <= req.msd;
            msd_reg   <= req.msd;
            first_reg <= 1'b1;
        end
        else if (run_reg)
        begin
            dig_reg   <= dig_reg - 1'b1;
            first_reg <= 1'b0;
        end
        if (run_reg)
        begin
            prod_reg   <= prod_next;
            pfirst_reg <= first_reg;
            plast_reg  <= (dig_reg == '0);
        end
        if (pv_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    assign stat.busy = run_reg | pv_reg;
    assign stat.done = done_reg;
    assign p         = acc_reg;

endmodule

// File: sv/third_order_state_observer_top.sv
// ----------------------------------------------------------------------------
// third_order_state_observer_top
// Third-order linear extended state observer with bandwidth-set gains. Each
// sample word (angle, control effort, step time) produces one estimate word
// with the updated angle, rate and disturbance estimates, saturated Q16.16.
// A sample runs seven multiplications through one shared multiplier that
// takes one 16-bit digit of its b operand per cycle before its estimate is
// registered; the next sample is taken once the sequencer is back in idle,
// which it reaches when the previous estimate has left or leaves then. A
// write to the bandwidth register recomputes the gains on the same
// multiplier; both the sample and register channels hold ready low
// meanwhile. A register write wins over a sample offered in the same cycle.
// ----------------------------------------------------------------------------
module third_order_state_observer_top #(
    parameter int STATE_WIDTH = 48
) (
    input  logic        clk,
    input  logic        rst_n,
    toso_sample_if.sink sample,
    toso_est_if.source  estimate,
    toso_cfg_if.sink    cfg
);
    import toso_pkg::*;

    localparam int SW    = STATE_WIDTH;
    localparam int ACC_W = SW + OPB_W;
    localparam int SUM_W = ACC_W + 2;

    localparam logic signed [SUM_W-1:0] ST_MAX = {{(SUM_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] ST_MIN = ~ST_MAX;
    localparam logic signed [SUM_W-1:0] WD_MAX = {{(SUM_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] WD_MIN = ~WD_MAX;

    localparam int ST_W = 5;
    localparam logic [ST_W-1:0] S_IDLE    = 5'd0;
    localparam logic [ST_W-1:0] S_GSQ_S   = 5'd1;
    localparam logic [ST_W-1:0] S_GSQ_W   = 5'd2;
    localparam logic [ST_W-1:0] S_GCUBE_W = 5'd3;
    localparam logic [ST_W-1:0] S_ERR     = 5'd4;
    localparam logic [ST_W-1:0] S_T1_S    = 5'd5;
    localparam logic [ST_W-1:0] S_T1_W    = 5'd6;
    localparam logic [ST_W-1:0] S_Z1_S    = 5'd7;
    localparam logic [ST_W-1:0] S_Z1_W    = 5'd8;
    localparam logic [ST_W-1:0] S_BU_S    = 5'd9;
    localparam logic [ST_W-1:0] S_BU_W    = 5'd10;
    localparam logic [ST_W-1:0] S_T2_S    = 5'd11;
    localparam logic [ST_W-1:0] S_T2_W    = 5'd12;
    localparam logic [ST_W-1:0] S_Z2_S    = 5'd13;
    localparam logic [ST_W-1:0] S_Z2_W    = 5'd14;
    localparam logic [ST_W-1:0] S_T3_S    = 5'd15;
    localparam logic [ST_W-1:0] S_T3_W    = 5'd16;
    localparam logic [ST_W-1:0] S_Z3_S    = 5'd17;
    localparam logic [ST_W-1:0] S_Z3_W    = 5'd18;
    localparam logic [ST_W-1:0] S_OUT     = 5'd19;

    function automatic logic signed [SW-1:0] sat_st(input logic signed [SUM_W-1:0] v);
        if (v > ST_MAX)
        begin
            return ST_MAX[SW-1:0];
        end
        else if (v < ST_MIN)
        begin
            return ST_MIN[SW-1:0];
        end
        return v[SW-1:0];
    endfunction

    function automatic logic signed [OUT_W-1:0] to_word(input logic signed [SW-1:0] z);
        logic signed [SUM_W-1:0] v;
        v = SUM_W'(z) >>> OUT_SHIFT;
        if (v > WD_MAX)
        begin
            return WD_MAX[OUT_W-1:0];
        end
        else if (v < WD_MIN)
        begin
            return WD_MIN[OUT_W-1:0];
        end
        return v[OUT_W-1:0];
    endfunction

    logic [ST_W-1:0] state_reg;
    logic [ST_W-1:0] state_next;

    logic        [BW_W-1:0]     bw_reg;
    logic signed [B0_W-1:0]     b0_reg;
    logic        [G1_W-1:0]     g1_reg;
    logic        [G2_W-1:0]     g2_reg;
    logic        [G3_W-1:0]     g3_reg;
    logic signed [ANGLE_W-1:0]  theta_reg;
    logic signed [EFFORT_W-1:0] u_reg;
    logic        [STEP_W-1:0]   dt_reg;
    logic signed [SW-1:0]       e_reg;
    logic signed [SW-1:0]       t_reg;
    logic signed [BU_W-1:0]     bu_reg;
    logic signed [SW-1:0]       z1_reg;
    logic signed [SW-1:0]       z2_reg;
    logic signed [SW-1:0]       z3_reg;
    logic                       est_vld_reg;
    logic signed [OUT_W-1:0]    ang_out_reg;
    logic signed [OUT_W-1:0]    rate_out_reg;
    logic signed [OUT_W-1:0]    dist_out_reg;

    mul_req_t                 mul_req;
    mul_stat_t                mul_stat;
    logic signed [SW-1:0]     mul_a;
    logic signed [OPB_W-1:0]  mul_b;
    logic signed [ACC_W-1:0]  mul_p;

    logic                     cfg_acc;
    logic                     smp_acc;
    logic                     out_free;
    logic signed [SUM_W-1:0]  p_sx;
    logic signed [SUM_W-1:0]  e_sum;
    logic signed [SUM_W-1:0]  t1_sum;
    logic signed [SUM_W-1:0]  t2_sum;
    logic signed [SUM_W-1:0]  t3_sum;
    logic signed [SW-1:0]     z_cur;
    logic signed [SUM_W-1:0]  z_sum;
    logic        [SQ_W-1:0]   sq;

    assign cfg.ready    = (state_reg == S_IDLE);
    assign sample.ready = (state_reg == S_IDLE) && !cfg.valid;
    assign cfg_acc      = cfg.valid && cfg.ready;
    assign smp_acc      = sample.valid && sample.ready;
    assign out_free     = !est_vld_reg || estimate.ready;

    assign estimate.valid                = est_vld_reg;
    assign estimate.angle_estimate       = ang_out_reg;
    assign estimate.rate_estimate        = rate_out_reg;
    assign estimate.disturbance_estimate = dist_out_reg;

    toso_mul #(
        .AW (SW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .a     (mul_a),
        .b     (mul_b),
        .stat  (mul_stat),
        .p     (mul_p)
    );

    always_comb
    begin
        sq     = mul_p[SQ_W-1:0];
        p_sx   = SUM_W'(mul_p);
        e_sum  = (SUM_W'(theta_reg) <<< ANGLE_SHIFT) - SUM_W'(z1_reg);
        t1_sum = SUM_W'(z2_reg) + (p_sx >>> GAIN1_FRAC);
        t2_sum = SUM_W'(z3_reg) + SUM_W'(bu_reg) + (p_sx >>> GAIN2_FRAC);
        t3_sum = p_sx >>> GAIN3_FRAC;
        case (state_reg)
            S_Z1_W:  z_cur = z1_reg;
            S_Z2_W:  z_cur = z2_reg;
            default: z_cur = z3_reg;
        endcase
        z_sum = SUM_W'(z_cur) + (p_sx >>> STEP_FRAC);
    end

    // multiplier operand selection and sequencing
    always_comb
    begin
        state_next    = state_reg;
        mul_req.start = 1'b0;
        mul_req.msd   = MSD_STEP;
        mul_a         = '0;
        mul_b         = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (cfg_acc && cfg.index == REG_BANDWIDTH)
                begin
                    state_next = S_GSQ_S;
                end
                else if (smp_acc)
                begin
                    state_next = S_ERR;
                end
            end
            S_GSQ_S:
            begin
                mul_req.start = 1'b1;
                mul_req.msd   = MSD_BW;
                mul_a         = SW'(bw_reg);
                mul_b         = OPB_W'(bw_reg);
                state_next    = S_GSQ_W;
            end
            S_GSQ_W:
            begin
                if (mul_stat.done)
                begin
                    // chain straight into wo^2 * wo
                    mul_req.start = 1'b1;
                    mul_req.msd   = MSD_SQ;
                    mul_a         = SW'(bw_reg);
                    mul_b         = OPB_W'(sq);
                    state_next    = S_GCUBE_W;
                end
            end
            S_GCUBE_W:
            begin
                if (mul_stat.done)
                begin
                    state_next = S_IDLE;
                end
            end
            S_ERR:
            begin
                state_next = S_T1_S;
            end
            S_T1_S:
            begin
                mul_req.start = 1'b1;
                mul_req.msd   = MSD_G1;
                mul_a         = e_reg;
                mul_b         = OPB_W'(g1_reg);
                state_next    = S_T1_W;
            end
            S_Z1_S, S_Z2_S, S_Z3_S:
            begin
                mul_req.start = 1'b1;
                mul_req.msd   = MSD_STEP;
                mul_a         = t_reg;
                mul_b         = OPB_W'(dt_reg);
                state_next    = state_reg + 1'b1;
            end
            S_BU_S:
            begin
                mul_req.start = 1'b1;
                mul_req.msd   = MSD_EFFORT;
                mul_a         = SW'(b0_reg);
                mul_b         = OPB_W'(u_reg);
                state_next    = S_BU_W;
            end
            S_T2_S:
            begin
                mul_req.start = 1'b1;
                mul_req.msd   = MSD_G2;
                mul_a         = e_reg;
                mul_b         = OPB_W'(g2_reg);
                state_next    = S_T2_W;
            end
            S_T3_S:
            begin
                mul_req.start = 1'b1;
                mul_req.msd   = MSD_G3;
                mul_a         = e_reg;
                mul_b         = OPB_W'(g3_reg);
                state_next    = S_T3_W;
            end
            S_T1_W, S_Z1_W, S_BU_W, S_T2_W, S_Z2_W, S_T3_W, S_Z3_W:
            begin
                if (mul_stat.done)
                begin
                    state_next = state_reg + 1'b1;
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            bw_reg      <= '0;
            b0_reg      <= '0;
            g1_reg      <= '0;
            g2_reg      <= '0;
            g3_reg      <= '0;
            z1_reg      <= '0;
            z2_reg      <= '0;
            z3_reg      <= '0;
            est_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_acc && cfg.index == REG_BANDWIDTH)
            begin
                bw_reg <= cfg.data[BW_W-1:0];
                g1_reg <= G1_W'(cfg.data[BW_W-1:0]) + (G1_W'(cfg.data[BW_W-1:0]) << 1);
            end
            if (cfg_acc && cfg.index == REG_CONTROL_GAIN)
            begin
                b0_reg <= $signed(cfg.data[B0_W-1:0]);
            end
            if (state_reg == S_GSQ_W && mul_stat.done)
            begin
                g2_reg <= G2_W'(sq) + (G2_W'(sq) << 1);
            end
            if (state_reg == S_GCUBE_W && mul_stat.done)
            begin
                g3_reg <= mul_p[G3_W-1:0];
            end
            if (mul_stat.done && state_reg == S_Z1_W)
            begin
                z1_reg <= sat_st(z_sum);
            end
            if (mul_stat.done && state_reg == S_Z2_W)
            begin
                z2_reg <= sat_st(z_sum);
            end
            if (mul_stat.done && state_reg == S_Z3_W)
            begin
                z3_reg <= sat_st(z_sum);
            end
            if (state_reg == S_OUT && out_free)
            begin
                est_vld_reg <= 1'b1;
            end
            else if (estimate.ready)
            begin
                est_vld_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (smp_acc)
        begin
            theta_reg <= sample.measured_angle;
            u_reg     <= sample.control_effort;
            dt_reg    <= sample.step_time;
        end
        if (state_reg == S_ERR)
        begin
            e_reg <= sat_st(e_sum);
        end
        if (mul_stat.done)
        begin
            case (state_reg)
                S_T1_W:  t_reg  <= sat_st(t1_sum);
                S_T2_W:  t_reg  <= sat_st(t2_sum);
                S_T3_W:  t_reg  <= sat_st(t3_sum);
                S_BU_W:  bu_reg <= BU_W'(mul_p >>> B0U_SHIFT);
                default: t_reg  <= t_reg;
            endcase
        end
        if (state_reg == S_OUT && out_free)
        begin
            ang_out_reg  <= to_word(z1_reg);
            rate_out_reg <= to_word(z2_reg);
            dist_out_reg <= to_word(z3_reg);
        end
    end

    // the shared multiplier is never restarted while a product is in flight
    a_mul_idle: assert property (@(posedge clk) disable iff (!rst_n)
        mul_req.start |-> !mul_stat.busy)
        else $error("multiplier started while busy");

    // every finished product moves the sequencer on
    a_done_moves: assert property (@(posedge clk) disable iff (!rst_n)
        mul_stat.done |=> state_reg != $past(state_reg))
        else $error("product finished but sequencer stalled");

    // a zero step leaves the angle increment at zero
    a_zero_step: assert property (@(posedge clk) disable iff (!rst_n)
        (mul_stat.done && state_reg == S_Z1_W && dt_reg == '0) |-> mul_p == '0)
        else $error("nonzero increment with zero step time");

endmodule
